FILE: hdl/dqc_pkg.sv
// Shared types and constants for the double-ended queue core.
// Used by the cell, the chain and the top level; depends on nothing.
`timescale 1ns / 1ps

package dqc_pkg;

  localparam int WORD_W   = 32;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 6;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SHIFT_IN,
    OP_SHIFT_OUT,
    OP_ROTATE,
    OP_WRITE_TAIL
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [WORD_W-1:0]  value;
    logic signed [WORD_W-1:0]  wrap;
  } cell_ctrl_t;

endpackage

FILE: hdl/dqc_cell.sv
// One storage cell of the queue chain, holding a single word.
// Depends on dqc_pkg for the control struct and cell operations.
`timescale 1ns / 1ps

module dqc_cell #(
  parameter int IDX_W = 5,
  parameter int IDX   = 0
) (
  input  logic                              clk,
  input  dqc_pkg::cell_ctrl_t               ctrl,
  input  logic [IDX_W-1:0]                  pos,
  input  logic signed [dqc_pkg::WORD_W-1:0] left_word,
  input  logic signed [dqc_pkg::WORD_W-1:0] right_word,
  output logic signed [dqc_pkg::WORD_W-1:0] word,
  output logic signed [dqc_pkg::WORD_W-1:0] sel_word
);

  logic at_pos;

  assign at_pos   = (pos == IDX_W'(IDX));
  assign sel_word = at_pos ? word : '0;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      dqc_pkg::OP_SHIFT_IN: begin
        word <= left_word;
      end
      dqc_pkg::OP_SHIFT_OUT: begin
        word <= right_word;
      end
      dqc_pkg::OP_ROTATE: begin
        word <= at_pos ? ctrl.wrap : right_word;
      end
      dqc_pkg::OP_WRITE_TAIL: begin
        if (at_pos) begin
          word <= ctrl.value;
        end
      end
      default: begin
        word <= word;
      end
    endcase
  end

endmodule

FILE: hdl/dqc_chain.sv
// Row of queue cells with the front at cell zero, plus the tail read-out.
// Depends on dqc_pkg and dqc_cell.
`timescale 1ns / 1ps

module dqc_chain #(
  parameter int DEPTH = 32,
  parameter int IDX_W = 5
) (
  input  logic                              clk,
  input  dqc_pkg::cell_ctrl_t               ctrl,
  input  logic [IDX_W-1:0]                  pos,
  output logic signed [dqc_pkg::WORD_W-1:0] front_word,
  output logic signed [dqc_pkg::WORD_W-1:0] pick_word
);

  logic signed [dqc_pkg::WORD_W-1:0] words [DEPTH];
  logic signed [dqc_pkg::WORD_W-1:0] sels  [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [dqc_pkg::WORD_W-1:0] left_w;
    logic signed [dqc_pkg::WORD_W-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = ctrl.value;
    end else begin : g_mid_l
      assign left_w = words[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = words[i+1];
    end

    dqc_cell #(
      .IDX_W (IDX_W),
      .IDX   (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .pos        (pos),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (words[i]),
      .sel_word   (sels[i])
    );
  end

  assign front_word = words[0];

  always_comb begin
    pick_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      pick_word = pick_word | sels[i];
    end
  end

endmodule

FILE: hdl/double_ended_queue_core.sv
// Double-ended queue of signed 32-bit words built as a row of shifting cells.
// Depends on dqc_pkg and dqc_chain.
`timescale 1ns / 1ps

// With the result side ready, the core accepts one item per clock. A dump first
// enters the dump state and then emits the held elements from the front, as the
// chain rotates once per emitted word; no item is accepted until the tail
// element has been presented. Results sit in an output register, so a new item
// is taken in the same cycle as the previous result is taken. There is no
// clearing pass after reset.
module double_ended_queue_core #(
  parameter int DEPTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [dqc_pkg::CMD_W-1:0]           cmd,
  input  logic signed [dqc_pkg::WORD_W-1:0]   value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dqc_pkg::STATUS_W-1:0]        status,
  output logic signed [dqc_pkg::WORD_W-1:0]   word,
  output logic [dqc_pkg::FILL_W-1:0]          fill,
  output logic                                last
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic {
    S_RUN,
    S_DUMP
  } state_t;

  state_t                            state;
  logic [CNT_W-1:0]                  count;
  logic [IDX_W-1:0]                  step;

  dqc_pkg::cell_ctrl_t               ctrl;
  logic [IDX_W-1:0]                  pos;
  logic signed [dqc_pkg::WORD_W-1:0] front_word;
  logic signed [dqc_pkg::WORD_W-1:0] pick_word;

  logic             take;
  logic             emit_dump;
  logic             full;
  logic             empty;
  logic             dump_last;
  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] cnt_p1;

  assign in_ready  = (state == S_RUN) && (!out_valid || out_ready);
  assign take      = in_valid && in_ready;
  assign emit_dump = (state == S_DUMP) && (!out_valid || out_ready);
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign cnt_m1    = count - CNT_W'(1);
  assign cnt_p1    = count + CNT_W'(1);
  assign dump_last = (step == cnt_m1[IDX_W-1:0]);

  always_comb begin
    ctrl.op    = dqc_pkg::OP_HOLD;
    ctrl.value = value;
    ctrl.wrap  = front_word;
    pos        = cnt_m1[IDX_W-1:0];
    if (take) begin
      unique case (cmd)
        dqc_pkg::CMD_PUSH_FRONT: begin
          if (!full) begin
            ctrl.op = dqc_pkg::OP_SHIFT_IN;
          end
        end
        dqc_pkg::CMD_PUSH_BACK: begin
          pos = count[IDX_W-1:0];
          if (!full) begin
            ctrl.op = dqc_pkg::OP_WRITE_TAIL;
          end
        end
        dqc_pkg::CMD_POP_FRONT: begin
          if (!empty) begin
            ctrl.op = dqc_pkg::OP_SHIFT_OUT;
          end
        end
        default: begin
          ctrl.op = dqc_pkg::OP_HOLD;
        end
      endcase
    end else if (emit_dump) begin
      ctrl.op = dqc_pkg::OP_ROTATE;
    end
  end

  dqc_chain #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_chain (
    .clk        (clk),
    .ctrl       (ctrl),
    .pos        (pos),
    .front_word (front_word),
    .pick_word  (pick_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RUN;
      count     <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        out_valid <= 1'b1;
        status    <= dqc_pkg::ST_OK;
        word      <= '0;
        fill      <= dqc_pkg::FILL_W'(count);
        last      <= 1'b1;
        unique case (cmd) inside
          dqc_pkg::CMD_PUSH_FRONT, dqc_pkg::CMD_PUSH_BACK: begin
            if (full) begin
              status <= dqc_pkg::ST_FULL;
            end else begin
              count <= cnt_p1;
              fill  <= dqc_pkg::FILL_W'(cnt_p1);
            end
          end
          dqc_pkg::CMD_POP_FRONT: begin
            if (empty) begin
              status <= dqc_pkg::ST_EMPTY;
            end else begin
              word  <= front_word;
              count <= cnt_m1;
              fill  <= dqc_pkg::FILL_W'(cnt_m1);
            end
          end
          dqc_pkg::CMD_POP_BACK: begin
            if (empty) begin
              status <= dqc_pkg::ST_EMPTY;
            end else begin
              word  <= pick_word;
              count <= cnt_m1;
              fill  <= dqc_pkg::FILL_W'(cnt_m1);
            end
          end
          dqc_pkg::CMD_DUMP: begin
            if (empty) begin
              status <= dqc_pkg::ST_EMPTY;
            end else begin
              out_valid <= 1'b0;
              state     <= S_DUMP;
              step      <= '0;
            end
          end
          default: begin
            status <= dqc_pkg::ST_OK;
          end
        endcase
      end else if (emit_dump) begin
        out_valid <= 1'b1;
        status    <= dqc_pkg::ST_OK;
        word      <= front_word;
        fill      <= dqc_pkg::FILL_W'(count);
        last      <= dump_last;
        step      <= step + IDX_W'(1);
        if (dump_last) begin
          state <= S_RUN;
        end
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("element count exceeds the queue depth");

  a_dump_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP) |-> !in_ready)
    else $error("item accepted while a dump is in progress");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (take && (cmd == dqc_pkg::CMD_PUSH_FRONT || cmd == dqc_pkg::CMD_PUSH_BACK) && !full)
    |=> (count == $past(cnt_p1)))
    else $error("accepted push did not grow the queue");

  a_dump_ends: assert property (@(posedge clk) disable iff (rst)
    (emit_dump && dump_last) |=> (state == S_RUN && last && out_valid))
    else $error("dump did not finish on its tail element");

endmodule
